FILE: rtl/core/bsbm_pkg.sv
// ----------------------------------------------------------------------------
// bsbm_pkg
// Shared types and constants of the cubic B-spline blending matrix core.
// ----------------------------------------------------------------------------
`default_nettype none

package bsbm_pkg;

    // default knot width and fraction bits of the coefficients
    localparam int KnotBitsDef     = 32;
    localparam int CoefFracBitsDef = 24;

    // fixed widths of the port fields
    localparam int KnotFieldW = 32;
    localparam int CoefFieldW = 32;
    localparam int RowW       = 2;

    // rows of the matrix
    localparam logic [RowW-1:0] RowCubic = 2'd0;
    localparam logic [RowW-1:0] RowLin2  = 2'd1;
    localparam logic [RowW-1:0] RowLin1  = 2'd2;
    localparam logic [RowW-1:0] RowConst = 2'd3;

    // knot window word
    typedef struct packed {
        logic [KnotFieldW-1:0] knot_0;
        logic [KnotFieldW-1:0] knot_1;
        logic [KnotFieldW-1:0] knot_2;
        logic [KnotFieldW-1:0] knot_3;
        logic [KnotFieldW-1:0] knot_4;
        logic [KnotFieldW-1:0] knot_5;
    } t_knots;

    // matrix row word
    typedef struct packed {
        logic [RowW-1:0]              row_index;
        logic signed [CoefFieldW-1:0] coef_0;
        logic signed [CoefFieldW-1:0] coef_1;
        logic signed [CoefFieldW-1:0] coef_2;
        logic signed [CoefFieldW-1:0] coef_3;
        logic                         degenerate;
        logic                         last_row;
    } t_row;

endpackage

`default_nettype wire

FILE: rtl/core/bspline_blend_matrix_core.sv
// ----------------------------------------------------------------------------
// bspline_blend_matrix_core
// Blending matrix of one non-uniform cubic B-spline segment from six knots.
//
//  channel  ports                     dir  handshake
//  -------  ------------------------  ---  -----------------------------------
//  knots    i_knots, start, busy      in   word taken when start && !busy
//  rows     o_result, o_valid         out  one row word per cycle o_valid high
//
//  One window yields four row words on consecutive cycles; a new window
//  is not taken while busy is high, set by the single row port (busy is
//  high after a window is taken). From accept to row 0 a window passes
//  the span, sum, two multiply, COEF_FRAC_BITS+1 divide and one matrix
//  stage, then the row output. Reset is synchronous and clears valid
//  bits and counters; the receiver cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none

module bspline_blend_matrix_core #(
    parameter int KNOT_BITS      = bsbm_pkg::KnotBitsDef,
    parameter int COEF_FRAC_BITS = bsbm_pkg::CoefFracBitsDef
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  start,
    output logic                 busy,
    input  wire bsbm_pkg::t_knots i_knots,
    output logic                 o_valid,
    output bsbm_pkg::t_row       o_result
);

    localparam int K   = KNOT_BITS;
    localparam int F   = COEF_FRAC_BITS;
    localparam int OW  = K + 2;          // span sums
    localparam int H   = OW / 2;         // low part of multiplier operand
    localparam int HH  = OW - H;         // high part
    localparam int PW  = 2 * OW;         // products
    localparam int QW  = F + 1;          // quotient bits, one per divide stage
    localparam int MW  = F + 5;          // matrix entries, signed
    localparam int NP  = 7;              // products
    localparam int ND  = 6;              // divisions
    localparam int CW  = bsbm_pkg::CoefFieldW;

    // division lanes: numerator / denominator product indexes
    localparam int PN33 = 0, PN23 = 1, PN22 = 2, PDA = 3, PDB = 4, PDC = 5, PDD = 6;

    // weight factor of the linear and quadratic rows
    localparam logic signed [MW-1:0] Three = MW'(3);

    logic accept;
    assign accept = start && !busy;

    // accept spacing
    logic [1:0] r_gap, n_gap;
    always_comb begin
        if (accept) begin
            n_gap = 2'd3;
        end else if (r_gap != 2'd0) begin
            n_gap = r_gap - 2'd1;
        end else begin
            n_gap = 2'd0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap <= 2'd0;
        end else begin
            r_gap <= n_gap;
        end
    end
    assign busy = (r_gap != 2'd0);

    // stage 1: knot masking, spans and order check
    logic [63:0]  kx [0:5];
    logic [K-1:0] kk [0:5];
    assign kx[0] = 64'(i_knots.knot_0);
    assign kx[1] = 64'(i_knots.knot_1);
    assign kx[2] = 64'(i_knots.knot_2);
    assign kx[3] = 64'(i_knots.knot_3);
    assign kx[4] = 64'(i_knots.knot_4);
    assign kx[5] = 64'(i_knots.knot_5);

    logic         r1_v;
    logic         r1_bad;
    logic [K-1:0] r1_d [1:5];
    logic         n1_bad;

    always_comb begin
        n1_bad = 1'b0;
        for (int i = 0; i < 6; i++) begin
            kk[i] = kx[i][K-1:0];
        end
        for (int i = 1; i < 6; i++) begin
            if (kk[i] < kk[i-1]) begin
                n1_bad = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else begin
            r1_v <= accept;
        end
    end
    always_ff @(posedge i_clk) begin
        r1_bad <= n1_bad;
        for (int i = 1; i < 6; i++) begin
            r1_d[i] <= kk[i] - kk[i-1];
        end
    end

    // stage 2: span sums and zero denominator check
    logic          r2_v, r2_bad;
    logic [OW-1:0] r2_d2, r2_d3, r2_d23, r2_d34, r2_d234, r2_da, r2_dd;
    logic [OW-1:0] s_d23, s_d34, s_d234;
    assign s_d23  = OW'(r1_d[2]) + OW'(r1_d[3]);
    assign s_d34  = OW'(r1_d[3]) + OW'(r1_d[4]);
    assign s_d234 = s_d23 + OW'(r1_d[4]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else begin
            r2_v <= r1_v;
        end
    end
    always_ff @(posedge i_clk) begin
        r2_bad  <= r1_bad || (s_d23 == '0) || (s_d34 == '0);
        r2_d2   <= OW'(r1_d[2]);
        r2_d3   <= OW'(r1_d[3]);
        r2_d23  <= s_d23;
        r2_d34  <= s_d34;
        r2_d234 <= s_d234;
        r2_da   <= s_d23 + OW'(r1_d[1]);
        r2_dd   <= s_d34 + OW'(r1_d[5]);
    end

    // stage 3: partial products, operand y split in two halves
    logic [OW-1:0]   op_x [0:NP-1];
    logic [OW-1:0]   op_y [0:NP-1];
    assign op_x[PN33] = r2_d3;   assign op_y[PN33] = r2_d3;
    assign op_x[PN23] = r2_d2;   assign op_y[PN23] = r2_d3;
    assign op_x[PN22] = r2_d2;   assign op_y[PN22] = r2_d2;
    assign op_x[PDA]  = r2_da;   assign op_y[PDA]  = r2_d23;
    assign op_x[PDB]  = r2_d234; assign op_y[PDB]  = r2_d23;
    assign op_x[PDC]  = r2_d234; assign op_y[PDC]  = r2_d34;
    assign op_x[PDD]  = r2_dd;   assign op_y[PDD]  = r2_d34;

    logic              r3_v, r3_bad;
    logic [OW+H-1:0]   r3_plo [0:NP-1];
    logic [OW+HH-1:0]  r3_phi [0:NP-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else begin
            r3_v <= r2_v;
        end
    end
    always_ff @(posedge i_clk) begin
        r3_bad <= r2_bad;
        for (int p = 0; p < NP; p++) begin
            r3_plo[p] <= (OW+H)'(op_x[p]) * (OW+H)'(op_y[p][H-1:0]);
            r3_phi[p] <= (OW+HH)'(op_x[p]) * (OW+HH)'(op_y[p][OW-1:H]);
        end
    end

    // stage 4: partial product sum
    logic          r4_v, r4_bad;
    logic [PW-1:0] r4_prod [0:NP-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else begin
            r4_v <= r3_v;
        end
    end
    always_ff @(posedge i_clk) begin
        r4_bad <= r3_bad;
        for (int p = 0; p < NP; p++) begin
            r4_prod[p] <= PW'(r3_plo[p]) + (PW'(r3_phi[p]) << H);
        end
    end

    // divide lanes a, b, c, d, e, f
    logic [PW-1:0] dv_num [0:ND-1];
    logic [PW-1:0] dv_den [0:ND-1];
    assign dv_num[0] = r4_prod[PN33]; assign dv_den[0] = r4_prod[PDA];
    assign dv_num[1] = r4_prod[PN33]; assign dv_den[1] = r4_prod[PDB];
    assign dv_num[2] = r4_prod[PN33]; assign dv_den[2] = r4_prod[PDC];
    assign dv_num[3] = r4_prod[PN33]; assign dv_den[3] = r4_prod[PDD];
    assign dv_num[4] = r4_prod[PN23]; assign dv_den[4] = r4_prod[PDB];
    assign dv_num[5] = r4_prod[PN22]; assign dv_den[5] = r4_prod[PDB];

    // restoring divide pipeline, one quotient bit per stage
    logic          r_dv   [0:QW-1];
    logic          r_dbad [0:QW-1];
    logic [PW-1:0] r_rem  [0:QW-1][0:ND-1];
    logic [PW-1:0] r_den  [0:QW-1][0:ND-1];
    logic [QW-1:0] r_quo  [0:QW-1][0:ND-1];

    for (genvar s = 0; s < QW; s++) begin : g_div
        logic [PW:0]   trial [0:ND-1];
        logic [PW-1:0] den_in [0:ND-1];
        logic [QW-1:0] quo_in [0:ND-1];
        logic          v_in, bad_in;

        always_comb begin
            for (int l = 0; l < ND; l++) begin
                if (s == 0) begin
                    trial[l]  = {1'b0, dv_num[l]};
                    den_in[l] = dv_den[l];
                    quo_in[l] = '0;
                end else begin
                    trial[l]  = {r_rem[(s == 0) ? 0 : s-1][l], 1'b0};
                    den_in[l] = r_den[(s == 0) ? 0 : s-1][l];
                    quo_in[l] = r_quo[(s == 0) ? 0 : s-1][l];
                end
            end
            if (s == 0) begin
                v_in   = r4_v;
                bad_in = r4_bad;
            end else begin
                v_in   = r_dv[(s == 0) ? 0 : s-1];
                bad_in = r_dbad[(s == 0) ? 0 : s-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[s] <= 1'b0;
            end else begin
                r_dv[s] <= v_in;
            end
        end
        always_ff @(posedge i_clk) begin
            r_dbad[s] <= bad_in;
            for (int l = 0; l < ND; l++) begin
                r_den[s][l] <= den_in[l];
                if (trial[l] >= {1'b0, den_in[l]}) begin
                    r_rem[s][l] <= PW'(trial[l] - {1'b0, den_in[l]});
                    r_quo[s][l] <= {quo_in[l][QW-2:0], 1'b1};
                end else begin
                    r_rem[s][l] <= trial[l][PW-1:0];
                    r_quo[s][l] <= {quo_in[l][QW-2:0], 1'b0};
                end
            end
        end
    end

    // matrix stage
    logic signed [MW-1:0] ta, tb, tc, td, te, tf, one;
    assign ta  = signed'(MW'(r_quo[QW-1][0]));
    assign tb  = signed'(MW'(r_quo[QW-1][1]));
    assign tc  = signed'(MW'(r_quo[QW-1][2]));
    assign td  = signed'(MW'(r_quo[QW-1][3]));
    assign te  = signed'(MW'(r_quo[QW-1][4]));
    assign tf  = signed'(MW'(r_quo[QW-1][5]));
    assign one = signed'(MW'(1) << F);

    function automatic logic [CW-1:0] to_coef(input logic signed [MW-1:0] v);
        logic signed [63:0] w;
        w = 64'(v);
        return w[CW-1:0];
    endfunction

    logic signed [MW-1:0] m [0:3][0:2];
    always_comb begin
        m[0][0] = -ta;
        m[0][1] = ta + tb + tc;
        m[0][2] = -tb - tc - td;
        m[1][0] = Three * ta;
        m[1][1] = -(Three * (ta + tb));
        m[1][2] = Three * tb;
        m[2][0] = -(Three * ta);
        m[2][1] = Three * (ta - te);
        m[2][2] = Three * te;
        m[3][0] = ta;
        m[3][1] = one - ta - tf;
        m[3][2] = tf;
    end

    logic          r5_v;
    logic          r5_bad;
    logic [CW-1:0] r5_m [0:3][0:2];
    logic [CW-1:0] r5_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else begin
            r5_v <= r_dv[QW-1];
        end
    end
    always_ff @(posedge i_clk) begin
        r5_bad <= r_dbad[QW-1];
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 3; j++) begin
                r5_m[i][j] <= r_dbad[QW-1] ? '0 : to_coef(m[i][j]);
            end
        end
        r5_d <= r_dbad[QW-1] ? '0 : to_coef(td);
    end

    // row output, four words per matrix
    logic            r_act;
    logic [1:0]      r_row;
    logic            r_hbad;
    logic [CW-1:0]   r_hm [0:3][0:2];
    logic [CW-1:0]   r_hd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
            r_row <= bsbm_pkg::RowCubic;
        end else if (r5_v) begin
            r_act <= 1'b1;
            r_row <= bsbm_pkg::RowCubic;
        end else if (r_act) begin
            r_act <= (r_row != bsbm_pkg::RowConst);
            r_row <= r_row + 2'd1;
        end
    end
    always_ff @(posedge i_clk) begin
        if (r5_v) begin
            r_hbad <= r5_bad;
            r_hm   <= r5_m;
            r_hd   <= r5_d;
        end
    end

    assign o_valid = r_act;
    always_comb begin
        o_result.row_index  = r_row;
        o_result.coef_0     = r_hm[r_row][0];
        o_result.coef_1     = r_hm[r_row][1];
        o_result.coef_2     = r_hm[r_row][2];
        o_result.coef_3     = (r_row == bsbm_pkg::RowCubic) ? r_hd : '0;
        o_result.degenerate = r_hbad;
        o_result.last_row   = (r_row == bsbm_pkg::RowConst);
    end

    // checks
    a_rows_in_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_result.last_row) |=>
            (o_valid && o_result.row_index == $past(o_result.row_index) + 2'd1))
        else $error("row words out of order");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy low after accepted window");

    a_degenerate_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.degenerate) |->
            (o_result.coef_0 == '0 && o_result.coef_1 == '0 &&
             o_result.coef_2 == '0 && o_result.coef_3 == '0))
        else $error("degenerate row with nonzero weights");

endmodule

`default_nettype wire
